// File: src/assert_macros.svh
// Assertion macros for the RTL of the presence hold unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked property, switched off while reset is asserted (active low).
`define PHR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("presence hold unit: assertion failed");

// Checked property that also holds during reset.
`define PHR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("presence hold unit: assertion failed");

`else

`define PHR_ASSERT(lbl, clk, rstn, prop)
`define PHR_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: src/phr_pkg.sv
`timescale 1ns / 1ps

package phr_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_RX     = 2'd2
    } op_t;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_STX  = 8'h02;
    localparam logic [7:0] CH_ETX  = 8'h03;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_QM   = 8'h3F;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_ZERO = 8'h30;

    localparam logic [7:0] HOLD_RESET = 8'd240;
    localparam logic [5:0] NODE_RESET = 6'd49;

    // Frame position after STX plus five more bytes.
    localparam logic [2:0] FRAME_DONE = 3'd6;
    // Index of the final reply byte.
    localparam logic [2:0] REPLY_LAST = 3'd6;

    typedef enum logic {
        REG_HOLD_SECONDS = 1'b0,
        REG_NODE_DIGIT   = 1'b1
    } cfg_reg_t;

    function automatic logic [7:0] reply_byte(logic [2:0] idx, logic [5:0] node,
                                              logic held);
        logic [7:0] b;
        case (idx)
            3'd0:    b = CH_STX;
            3'd1:    b = CH_S;
            3'd2:    b = {2'b00, node};
            3'd3:    b = CH_M;
            3'd4:    b = held ? CH_ONE : CH_ZERO;
            3'd5:    b = CH_ETX;
            default: b = CH_NUL;
        endcase
        return b;
    endfunction

endpackage

// File: src/phr_frame_parser.sv
`timescale 1ns / 1ps

module phr_frame_parser
    import phr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_en,
    input  logic [7:0] rx_byte,
    input  logic       rx_last,
    input  logic [5:0] node_digit,
    output logic       poll_match
);

    logic [2:0] pos_reg, pos_next;
    logic       ok_reg, ok_next;
    logic       ended_reg, ended_next;
    logic [7:0] want;

    always_comb begin
        case (pos_reg)
            3'd1:    want = CH_M;
            3'd2:    want = CH_S;
            3'd3:    want = {2'b00, node_digit};
            3'd4:    want = CH_QM;
            default: want = CH_ETX;
        endcase
    end

    // Byte step: text after a NUL is dropped, the frame starts at the first STX.
    always_comb begin
        pos_next   = pos_reg;
        ok_next    = ok_reg;
        ended_next = ended_reg;
        if (!ended_reg) begin
            if (rx_byte == CH_NUL) begin
                ended_next = 1'b1;
            end else if (pos_reg == 3'd0) begin
                if (rx_byte == CH_STX) begin
                    pos_next = 3'd1;
                    ok_next  = 1'b1;
                end
            end else if (pos_reg < FRAME_DONE) begin
                if (rx_byte != want) begin
                    ok_next = 1'b0;
                end
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    assign poll_match = byte_en && rx_last && (pos_next == FRAME_DONE) && ok_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 3'd0;
            ok_reg    <= 1'b0;
            ended_reg <= 1'b0;
        end else if (byte_en) begin
            if (rx_last) begin
                pos_reg   <= 3'd0;
                ok_reg    <= 1'b0;
                ended_reg <= 1'b0;
            end else begin
                pos_reg   <= pos_next;
                ok_reg    <= ok_next;
                ended_reg <= ended_next;
            end
        end
    end

endmodule

// File: src/presence_hold_with_poll_reply_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  op, sensor_level, rx_byte, rx_last
// m_        out        m_valid / m_ready  kind, raw/held presence, tx_byte, tx_last
// cfg_      in         cfg_we             cfg_addr, cfg_wdata
//
// An input word is processed in the cycle it is accepted; its status or first reply
// word appears in the output register on the next cycle. With m_ready high, samples,
// ticks and radio bytes sustain one word per cycle, as do the seven reply words of a
// matching poll, shifted out of the output register by a byte index; input is held
// off while later reply words are still queued. Reset (aresetn low, synchronous)
// restores the flags, counter, parser and both registers to their reset values.

`include "assert_macros.svh"

module presence_hold_with_poll_reply_unit
    import phr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic       s_sensor_level,
    input  logic [7:0] s_rx_byte,
    input  logic       s_rx_last,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic       m_raw_presence,
    output logic       m_held_presence,
    output logic [7:0] m_tx_byte,
    output logic       m_tx_last,

    input  logic       cfg_we,
    input  logic       cfg_addr,
    input  logic [7:0] cfg_wdata
);

    // Configuration registers.
    logic [7:0] hold_reg;
    logic [5:0] node_reg;

    // Presence state.
    logic       raw_reg, raw_next;
    logic       held_reg, held_next;
    logic [7:0] count_reg, count_next;

    // Output register and reply sequencer.
    logic       m_valid_reg;
    logic       m_kind_reg;
    logic       m_raw_reg;
    logic       m_held_reg;
    logic [7:0] m_byte_reg;
    logic       m_last_reg;
    logic [2:0] reply_idx_reg;
    logic       reply_busy_reg;
    logic [2:0] reply_idx_next;

    logic s_take;
    logic m_take;
    logic is_status;
    logic is_rx;
    logic poll_match;

    assign m_take  = m_valid_reg && m_ready;
    // A new word may enter when no reply words are queued and the output register
    // is free or being emptied in this cycle.
    assign s_ready = !reply_busy_reg && (!m_valid_reg || m_ready);
    assign s_take  = s_valid && s_ready;

    assign is_status = (s_op == OP_SAMPLE) || (s_op == OP_TICK);
    assign is_rx     = (s_op == OP_RX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= HOLD_RESET;
            node_reg <= NODE_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_HOLD_SECONDS: hold_reg <= cfg_wdata;
                REG_NODE_DIGIT:   node_reg <= cfg_wdata[5:0];
                default:          ;
            endcase
        end
    end

    // Hold timer. The counter restarts on a rising edge of raw presence and
    // saturates at the hold time; held presence clears on a no-motion sample only
    // once the counter has reached the hold time.
    always_comb begin
        raw_next   = raw_reg;
        held_next  = held_reg;
        count_next = count_reg;
        case (s_op)
            OP_SAMPLE: begin
                if (!s_sensor_level) begin
                    raw_next = 1'b0;
                    if (held_reg && (count_reg >= hold_reg)) begin
                        held_next = 1'b0;
                    end
                end else begin
                    if (!raw_reg) begin
                        raw_next   = 1'b1;
                        count_next = 8'd0;
                    end
                    held_next = 1'b1;
                end
            end
            OP_TICK: begin
                if (count_reg < hold_reg) begin
                    count_next = count_reg + 8'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg   <= 1'b0;
            held_reg  <= 1'b0;
            count_reg <= 8'd0;
        end else if (s_take) begin
            raw_reg   <= raw_next;
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

    phr_frame_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_en    (s_take && is_rx),
        .rx_byte    (s_rx_byte),
        .rx_last    (s_rx_last),
        .node_digit (node_reg),
        .poll_match (poll_match)
    );

    assign reply_idx_next = reply_idx_reg + 3'd1;

    // Output register. The flags cannot change during a reply because no input
    // word is taken while reply words are queued, so the live flags are used.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            reply_busy_reg <= 1'b0;
            reply_idx_reg  <= 3'd0;
        end else if (reply_busy_reg) begin
            if (m_take) begin
                reply_idx_reg  <= reply_idx_next;
                reply_busy_reg <= (reply_idx_next != REPLY_LAST);
                m_valid_reg    <= 1'b1;
            end
        end else if (s_take && is_status) begin
            m_valid_reg <= 1'b1;
        end else if (s_take && poll_match) begin
            m_valid_reg    <= 1'b1;
            reply_busy_reg <= 1'b1;
            reply_idx_reg  <= 3'd0;
        end else if (m_take) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (reply_busy_reg) begin
            if (m_take) begin
                m_kind_reg <= 1'b1;
                m_raw_reg  <= raw_reg;
                m_held_reg <= held_reg;
                m_byte_reg <= reply_byte(reply_idx_next, node_reg, held_reg);
                m_last_reg <= (reply_idx_next == REPLY_LAST);
            end
        end else if (s_take && is_status) begin
            m_kind_reg <= 1'b0;
            m_raw_reg  <= raw_next;
            m_held_reg <= held_next;
            m_byte_reg <= CH_NUL;
            m_last_reg <= 1'b0;
        end else if (s_take && poll_match) begin
            m_kind_reg <= 1'b1;
            m_raw_reg  <= raw_reg;
            m_held_reg <= held_reg;
            m_byte_reg <= reply_byte(3'd0, node_reg, held_reg);
            m_last_reg <= 1'b0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_raw_presence  = m_raw_reg;
    assign m_held_presence = m_held_reg;
    assign m_tx_byte       = m_byte_reg;
    assign m_tx_last       = m_last_reg;

    // Queued reply words always sit behind a valid output word and block input.
    `PHR_ASSERT(a_busy_blocks_input, aclk, aresetn, reply_busy_reg |-> (m_valid_reg && !s_ready))
    // The final reply word is a reply byte holding NUL and ends the burst.
    `PHR_ASSERT(a_last_is_nul, aclk, aresetn, (m_valid_reg && m_last_reg) |-> (m_kind_reg && (m_byte_reg == CH_NUL) && !reply_busy_reg))
    // Raw presence implies held presence.
    `PHR_ASSERT(a_raw_implies_held, aclk, aresetn, raw_reg |-> held_reg)
    // A stalled output word stays in place.
    `PHR_ASSERT(a_out_holds, aclk, aresetn, (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_byte_reg) && $stable(m_kind_reg)))

endmodule

// File: tb/sv/tb_presence_hold_with_poll_reply_unit.sv
`timescale 1ns / 1ps

module tb_presence_hold_with_poll_reply_unit;
    import phr_pkg::*;

    // The op value that the block does not decode; such a word is swallowed silently.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Input words per random phase, counting only words the block acts on.
    localparam int PHASE_WORDS = 45;
    localparam int PHASE_COUNT = 8;
    // Extra cycles after the last expected word before the block is called idle.
    localparam int SETTLE_CYCLES = 4;
    // Cycles without any accepted word before the run is declared hung.
    localparam int IDLE_LIMIT = 1000;

    // One output word, in the order of the output ports.
    typedef struct packed {
        logic       kind;
        logic       raw_presence;
        logic       held_presence;
        logic [7:0] tx_byte;
        logic       tx_last;
    } out_word_t;

    // Tracks presence flags, the hold counter and the poll parser exactly as the block
    // should, and keeps the output words that are still owed in arrival order.
    class presence_tracker;
        logic [7:0] hold_seconds;
        logic [5:0] node_id;
        logic       raw_on;
        logic       held_on;
        logic [7:0] secs;
        logic [2:0] frame_pos;
        logic       frame_good;
        logic       text_done;
        out_word_t  due_words[$];
        int         errors;

        function new();
            hold_seconds = HOLD_RESET;
            node_id      = NODE_RESET;
            raw_on       = 1'b0;
            held_on      = 1'b0;
            secs         = 8'd0;
            frame_pos    = 3'd0;
            frame_good   = 1'b0;
            text_done    = 1'b0;
            errors       = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [7:0] value);
            if (idx == REG_HOLD_SECONDS) begin
                hold_seconds = value;
            end else begin
                node_id = value[5:0];
            end
        endfunction

        function void queue_word(logic kind, logic [7:0] b, logic last);
            out_word_t w;
            w.kind          = kind;
            w.raw_presence  = raw_on;
            w.held_presence = held_on;
            w.tx_byte       = b;
            w.tx_last       = last;
            due_words.push_back(w);
        endfunction

        // Poll frame parser: hunt for STX, then compare the next five bytes.
        function void parse_byte(logic [7:0] b);
            logic [7:0] wanted;
            if (text_done) begin
                return;
            end
            if (b == CH_NUL) begin
                text_done = 1'b1;
                return;
            end
            if (frame_pos == 3'd0) begin
                if (b == CH_STX) begin
                    frame_pos  = 3'd1;
                    frame_good = 1'b1;
                end
                return;
            end
            if (frame_pos >= FRAME_DONE) begin
                return;
            end
            case (frame_pos)
                3'd1:    wanted = CH_M;
                3'd2:    wanted = CH_S;
                3'd3:    wanted = {2'b00, node_id};
                3'd4:    wanted = CH_QM;
                default: wanted = CH_ETX;
            endcase
            if (b != wanted) begin
                frame_good = 1'b0;
            end
            frame_pos = frame_pos + 3'd1;
        endfunction

        function void absorb_input(logic [1:0] op, logic level, logic [7:0] b, logic last);
            logic answer;
            case (op)
                OP_SAMPLE: begin
                    if (!level) begin
                        raw_on = 1'b0;
                        if (held_on && secs >= hold_seconds) begin
                            held_on = 1'b0;
                        end
                    end else begin
                        if (!raw_on) begin
                            raw_on = 1'b1;
                            secs   = 8'd0;
                        end
                        held_on = 1'b1;
                    end
                    queue_word(1'b0, CH_NUL, 1'b0);
                end
                OP_TICK: begin
                    if (secs < hold_seconds) begin
                        secs = secs + 8'd1;
                    end
                    queue_word(1'b0, CH_NUL, 1'b0);
                end
                OP_RX: begin
                    parse_byte(b);
                    if (last) begin
                        answer     = (frame_pos == FRAME_DONE) && frame_good;
                        frame_pos  = 3'd0;
                        frame_good = 1'b0;
                        text_done  = 1'b0;
                        if (answer) begin
                            queue_word(1'b1, CH_STX, 1'b0);
                            queue_word(1'b1, CH_S, 1'b0);
                            queue_word(1'b1, {2'b00, node_id}, 1'b0);
                            queue_word(1'b1, CH_M, 1'b0);
                            queue_word(1'b1, held_on ? CH_ONE : CH_ZERO, 1'b0);
                            queue_word(1'b1, CH_ETX, 1'b0);
                            queue_word(1'b1, CH_NUL, 1'b1);
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void compare_output(out_word_t got);
            out_word_t want;
            if (due_words.size() == 0) begin
                $error("output word with nothing owed: kind %0d tx_byte %h",
                       got.kind, got.tx_byte);
                errors++;
                return;
            end
            want = due_words.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.raw_presence !== want.raw_presence) begin
                $error("raw_presence: expected %0d, got %0d",
                       want.raw_presence, got.raw_presence);
                errors++;
            end
            if (got.held_presence !== want.held_presence) begin
                $error("held_presence: expected %0d, got %0d",
                       want.held_presence, got.held_presence);
                errors++;
            end
            if (got.tx_byte !== want.tx_byte) begin
                $error("tx_byte: expected %h, got %h", want.tx_byte, got.tx_byte);
                errors++;
            end
            if (got.tx_last !== want.tx_last) begin
                $error("tx_last: expected %0d, got %0d", want.tx_last, got.tx_last);
                errors++;
            end
        endfunction

        function int pending();
            return due_words.size();
        endfunction
    endclass

    // All block inputs start at known values at time zero.
    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic [1:0] s_op           = 2'd0;
    logic       s_sensor_level = 1'b0;
    logic [7:0] s_rx_byte      = 8'd0;
    logic       s_rx_last      = 1'b0;
    logic       m_ready        = 1'b0;
    logic       cfg_we         = 1'b0;
    logic       cfg_addr       = 1'b0;
    logic [7:0] cfg_wdata      = 8'd0;

    logic       s_ready;
    logic       m_valid;
    logic       m_kind;
    logic       m_raw_presence;
    logic       m_held_presence;
    logic [7:0] m_tx_byte;
    logic       m_tx_last;

    presence_tracker tracker;

    // When set, the matching side runs without random idle cycles.
    bit         quiet_sender = 1'b0;
    bit         quiet_sink   = 1'b0;
    int         words_sent;
    int         idle_cycles  = 0;
    logic [7:0] pkt_bytes[$];

    presence_hold_with_poll_reply_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_sensor_level  (s_sensor_level),
        .s_rx_byte       (s_rx_byte),
        .s_rx_last       (s_rx_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_raw_presence  (m_raw_presence),
        .m_held_presence (m_held_presence),
        .m_tx_byte       (m_tx_byte),
        .m_tx_last       (m_tx_last),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Monitor and watchdog. Everything is sampled at the rising edge, before the
    // nonblocking updates of that edge land, so both handshakes are seen exactly as
    // the block sees them. An output word is checked before the input word of the
    // same edge is noted; the input cannot affect that output word anyway.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                tracker.compare_output(out_word_t'({m_kind, m_raw_presence,
                                                    m_held_presence, m_tx_byte,
                                                    m_tx_last}));
            end
            if (s_valid && s_ready) begin
                tracker.absorb_input(s_op, s_sensor_level, s_rx_byte, s_rx_last);
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_presence_hold_with_poll_reply_unit NOT OK");
                $finish;
            end
        end
    end

    // Output side: before each word it draws a random stall, which may be zero, with ready low,
    // then holds ready high until a word is taken. A zero stall leaves ready high, so
    // ready is never lowered and raised within one time step.
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = quiet_sink ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Presents one input word after a random gap and returns at the edge that takes
    // it. With no gap, valid stays high straight into the next word.
    task automatic send_word(input logic [1:0] op, input logic level,
                             input logic [7:0] b, input logic last);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_sensor_level <= level;
        s_rx_byte      <= b;
        s_rx_last      <= last;
        do @(posedge aclk); while (!s_ready);
        if (op != OP_UNUSED) begin
            words_sent++;
        end
    endtask

    // Sends the bytes in pkt_bytes as one radio packet, flagging the final byte. The
    // fields that radio words do not use carry random values.
    task automatic send_packet();
        int k;
        for (k = 0; k < pkt_bytes.size(); k++) begin
            send_word(OP_RX, 1'($urandom), pkt_bytes[k], k == pkt_bytes.size() - 1);
        end
    endtask

    // Stops the input side and waits until every owed word has come out, plus a few
    // cycles in case the last word was a radio byte still being parsed. The first
    // edge is always waited so the monitor has noted the last accepted word.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write, only ever called while the block is idle. It returns with the
    // enable low, so back-to-back writes never touch the enable twice in one step.
    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        tracker.set_reg(idx, value);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Builds a radio packet. Most packets carry a poll addressed to this node, with
    // optional junk before the STX and after the ETX; the rest are polls with a bad
    // byte (often a second STX), polls for another node, cut-short frames, frames
    // with an early NUL, and plain noise.
    task automatic random_packet();
        int         variant;
        int         cut;
        int         k;
        logic [7:0] frame[6];
        frame   = '{CH_STX, CH_M, CH_S, {2'b00, tracker.node_id}, CH_QM, CH_ETX};
        variant = $urandom_range(0, 99);
        cut     = 0;
        pkt_bytes.delete();
        if (variant >= 93) begin
            for (k = $urandom_range(1, 6); k > 0; k--) begin
                pkt_bytes.push_back(8'($urandom));
            end
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                pkt_bytes.push_back(8'($urandom_range(8'h20, 8'hFF)));
            end
            if (variant >= 55 && variant < 68) begin
                frame[$urandom_range(1, 5)] = $urandom_range(0, 1) ? CH_STX : 8'($urandom);
            end else if (variant >= 68 && variant < 76) begin
                frame[3] = {2'b00, tracker.node_id ^ 6'd1};
            end else if (variant >= 76 && variant < 86) begin
                cut = $urandom_range(1, 5);
            end else if (variant >= 86) begin
                frame[$urandom_range(1, 5)] = CH_NUL;
            end
            for (k = 0; k < 6 - cut; k++) begin
                pkt_bytes.push_back(frame[k]);
            end
            // Trailing text after the frame, sometimes opened by a NUL.
            if ($urandom_range(0, 2) == 0) begin
                pkt_bytes.push_back($urandom_range(0, 1) ? CH_NUL : 8'($urandom));
                if ($urandom_range(0, 1) == 0) begin
                    pkt_bytes.push_back(8'($urandom));
                end
            end
        end
        send_packet();
    endtask

    // One random step: mostly samples and ticks so the hold timer gets exercised,
    // some packets, and a few words with the undecoded op value.
    task automatic random_step();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_word(OP_SAMPLE, 1'($urandom), 8'($urandom), 1'($urandom));
        end else if (pick < 76) begin
            send_word(OP_TICK, 1'($urandom), 8'($urandom), 1'($urandom));
        end else if (pick < 80) begin
            send_word(OP_UNUSED, 1'($urandom), 8'($urandom), 1'($urandom));
        end else begin
            random_packet();
        end
    endtask

    initial begin
        int         phase;
        bit         paused;
        logic [7:0] hold_val;
        logic [7:0] node_val;

        tracker = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part with the reset settings (hold 240, node '1'). Motion onset,
        // a tick, motion stopping while the hold is still running, an ignored word,
        // a new onset, then a clean poll, a poll with text after the ETX, a frame cut
        // by a NUL, and a packet that is two STX bytes.
        send_word(OP_SAMPLE, 1'b1, 8'h00, 1'b0);
        send_word(OP_TICK, 1'b0, 8'hFF, 1'b1);
        send_word(OP_SAMPLE, 1'b0, 8'hFF, 1'b1);
        send_word(OP_UNUSED, 1'b1, CH_STX, 1'b1);
        send_word(OP_SAMPLE, 1'b1, 8'h00, 1'b0);
        send_word(OP_SAMPLE, 1'b1, 8'h80, 1'b0);
        pkt_bytes = '{CH_STX, CH_M, CH_S, CH_ONE, CH_QM, CH_ETX};
        send_packet();
        pkt_bytes = '{CH_STX, CH_M, CH_S, CH_ONE, CH_QM, CH_ETX, 8'hC1};
        send_packet();
        pkt_bytes = '{CH_STX, CH_M, CH_NUL, CH_ETX};
        send_packet();
        pkt_bytes = '{CH_STX, CH_STX};
        send_packet();
        wait_drained();

        // Random phases, each with its own register settings. The settings cover the
        // smallest and largest hold, a hold of zero, node values that are not digits
        // (including a NUL node, which can never match), and write data whose upper
        // bits must be dropped for the node register.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    hold_val = 8'd1;
                    node_val = 8'd48;
                end
                1: begin
                    hold_val = 8'd255;
                    node_val = 8'd57;
                end
                2: begin
                    hold_val = 8'd0;
                    node_val = 8'hF2;
                end
                3: begin
                    hold_val = 8'd2;
                    node_val = 8'hFF;
                end
                4: begin
                    hold_val = HOLD_RESET;
                    node_val = {2'b00, NODE_RESET};
                end
                5: begin
                    hold_val = 8'($urandom_range(1, 8));
                    node_val = 8'($urandom_range(48, 57));
                end
                6: begin
                    hold_val = 8'($urandom_range(1, 12));
                    node_val = 8'h00;
                end
                default: begin
                    hold_val = 8'd5;
                    node_val = 8'd55;
                end
            endcase
            write_reg(REG_HOLD_SECONDS, hold_val);
            write_reg(REG_NODE_DIGIT, node_val);

            // One phase runs both sides flat out, another only the output side.
            quiet_sender = (phase == 4);
            quiet_sink   = (phase == 4) || (phase == 6);

            words_sent = 0;
            paused     = 1'b0;
            while (words_sent < PHASE_WORDS) begin
                random_step();
                // Halfway through, let the output side catch up completely.
                if (!paused && words_sent >= PHASE_WORDS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            wait_drained();
        end

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb_presence_hold_with_poll_reply_unit OK");
        end else begin
            $display("tb_presence_hold_with_poll_reply_unit NOT OK");
        end
        $finish;
    end

endmodule
